[hw/rtl/stt_pkg.sv]
// Shared types, token kind codes and keyword table for the source text tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

	// One byte of source text and its end-of-text flag.
	typedef struct packed {
		logic [7:0] ch;
		logic       final_byte;
	} char_t;

	// One finished token.
	typedef struct packed {
		logic [5:0]  kind;
		logic [31:0] start_offset;
		logic [15:0] token_length;
		logic [15:0] line;
		logic [7:0]  bad_char;
		logic        last_of_run;
	} tok_t;

	// Up to two tokens produced by one byte, in emission order.
	typedef struct packed {
		logic [1:0] cnt;
		tok_t       first;
		tok_t       second;
	} res_pair_t;

	localparam logic [5:0] KIND_STRING  = 6'd0;
	localparam logic [5:0] KIND_NUMBER  = 6'd1;
	localparam logic [5:0] KIND_COMMENT = 6'd2;
	localparam logic [5:0] KIND_IDENT   = 6'd3;
	localparam logic [5:0] KIND_KW0     = 6'd4;
	localparam logic [5:0] KIND_ASSIGN  = 6'd17;
	localparam logic [5:0] KIND_COLON   = 6'd18;
	localparam logic [5:0] KIND_LE      = 6'd19;
	localparam logic [5:0] KIND_LT      = 6'd20;
	localparam logic [5:0] KIND_GE      = 6'd21;
	localparam logic [5:0] KIND_GT      = 6'd22;
	localparam logic [5:0] KIND_EQ      = 6'd23;
	localparam logic [5:0] KIND_NE      = 6'd24;
	localparam logic [5:0] KIND_LOGIC   = 6'd25;
	localparam logic [5:0] KIND_SEMI    = 6'd26;
	localparam logic [5:0] KIND_PLUS    = 6'd27;
	localparam logic [5:0] KIND_MINUS   = 6'd28;
	localparam logic [5:0] KIND_STAR    = 6'd29;
	localparam logic [5:0] KIND_SLASH   = 6'd30;
	localparam logic [5:0] KIND_LPAREN  = 6'd31;
	localparam logic [5:0] KIND_RPAREN  = 6'd32;
	localparam logic [5:0] KIND_LBRACE  = 6'd33;
	localparam logic [5:0] KIND_RBRACE  = 6'd34;
	localparam logic [5:0] KIND_COMMA   = 6'd35;
	localparam logic [5:0] KIND_ERR     = 6'd36;

	// Keywords packed first character highest, zero above the text.
	localparam int KW_COUNT = 13;
	localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
		48'("int"), 48'("float"), 48'("string"), 48'("read"), 48'("write"),
		48'("repeat"), 48'("until"), 48'("if"), 48'("elseif"), 48'("else"),
		48'("then"), 48'("return"), 48'("end")
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{
		3'd3, 3'd5, 3'd6, 3'd4, 3'd5, 3'd6, 3'd5, 3'd2, 3'd6, 3'd4, 3'd4, 3'd6, 3'd3
	};

	// Result queue geometry.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

endpackage

`default_nettype wire

[hw/rtl/stt_scan_core.sv]
// Scanner state and the single-pass next-state and token logic for one byte.
`timescale 1ns / 1ps
`default_nettype none

module stt_scan_core #(
	parameter int POSITION_BITS     = 32,
	parameter int LINE_BITS         = 16,
	parameter int KEYWORD_MAX_CHARS = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire stt_pkg::char_t    char_data,
	output stt_pkg::res_pair_t     results
);

	localparam int PW  = POSITION_BITS;
	localparam int LW  = LINE_BITS;
	localparam int PFW = 8 * KEYWORD_MAX_CHARS;

	typedef enum logic [3:0] {
		M_IDLE, M_STR, M_NUM, M_CMT, M_IDENT, M_SLASH,
		M_COLON, M_LT, M_GT, M_BANG, M_AMP, M_PIPE
	} mode_t;

	mode_t            mode_q;
	logic [PW-1:0]    pos_q;
	logic [LW-1:0]    line_q;
	logic [PW-1:0]    tstart_q;
	logic [LW-1:0]    tline_q;
	logic [15:0]      tlen_q;
	logic [PFW-1:0]   pref_q;
	logic             star_q;

	mode_t            md, fm;
	logic [PW-1:0]    pos_nx, ts;
	logic [LW-1:0]    line_nx, tl;
	logic [15:0]      len;
	logic [PFW-1:0]   pf;
	logic             st, used;
	logic [7:0]       c;
	logic             a_v, b_v, f_v;
	stt_pkg::tok_t    a_t, b_t, f_t;

	function automatic logic is_digit(input logic [7:0] v);
		return v >= "0" && v <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] v);
		return (v >= "a" && v <= "z") || (v >= "A" && v <= "Z");
	endfunction

	function automatic logic is_space(input logic [7:0] v);
		return v == " " || (v >= 8'd9 && v <= 8'd13);
	endfunction

	function automatic logic [15:0] grow(input logic [15:0] v);
		return (v != 16'hFFFF) ? v + 16'd1 : v;
	endfunction

	function automatic logic [31:0] start32(input logic [PW-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[31:0];
	endfunction

	function automatic logic [15:0] sat_line(input logic [LW-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic logic [5:0] word_kind(input logic [15:0] n, input logic [PFW-1:0] p);
		logic [5:0] k;
		k = stt_pkg::KIND_IDENT;
		if (n <= 16'(KEYWORD_MAX_CHARS)) begin
			for (int i = 0; i < stt_pkg::KW_COUNT; i++) begin
				if (n == 16'(stt_pkg::KW_LEN[i]) && p == PFW'(stt_pkg::KW_TEXT[i]))
					k = stt_pkg::KIND_KW0 + 6'(i);
			end
		end
		return k;
	endfunction

	// Emit the pending token as it stands.
	function automatic stt_pkg::tok_t flush_tok(input mode_t m, input logic [PW-1:0] s,
			input logic [15:0] n, input logic [LW-1:0] l, input logic [PFW-1:0] p);
		stt_pkg::tok_t t;
		t = '0;
		t.start_offset = start32(s);
		t.line         = sat_line(l);
		t.token_length = 16'd1;
		unique case (m)
			M_STR:   begin t.kind = stt_pkg::KIND_STRING;  t.token_length = n; end
			M_NUM:   begin t.kind = stt_pkg::KIND_NUMBER;  t.token_length = n; end
			M_CMT:   begin t.kind = stt_pkg::KIND_COMMENT; t.token_length = n; end
			M_IDENT: begin t.kind = word_kind(n, p);       t.token_length = n; end
			M_SLASH: t.kind = stt_pkg::KIND_SLASH;
			M_COLON: t.kind = stt_pkg::KIND_COLON;
			M_LT:    t.kind = stt_pkg::KIND_LT;
			M_GT:    t.kind = stt_pkg::KIND_GT;
			M_BANG:  begin t.kind = stt_pkg::KIND_ERR; t.bad_char = "!"; end
			M_AMP:   begin t.kind = stt_pkg::KIND_ERR; t.bad_char = "&"; end
			M_PIPE:  begin t.kind = stt_pkg::KIND_ERR; t.bad_char = "|"; end
			default: t.token_length = 16'd0;
		endcase
		return t;
	endfunction

	function automatic logic [7:0] pair_second(input mode_t m);
		unique case (m)
			M_AMP:   return "&";
			M_PIPE:  return "|";
			default: return "=";
		endcase
	endfunction

	function automatic logic [5:0] pair_kind(input mode_t m);
		unique case (m)
			M_COLON: return stt_pkg::KIND_ASSIGN;
			M_LT:    return stt_pkg::KIND_LE;
			M_GT:    return stt_pkg::KIND_GE;
			M_BANG:  return stt_pkg::KIND_NE;
			default: return stt_pkg::KIND_LOGIC;
		endcase
	endfunction

	// Mode a byte opens when scanned fresh; idle for single-byte tokens.
	function automatic mode_t fresh_mode(input logic [7:0] v);
		if (v == "\"")                       return M_STR;
		if (is_digit(v))                     return M_NUM;
		if (v == "/")                        return M_SLASH;
		if (is_alpha(v) || v == "_")         return M_IDENT;
		unique case (v)
			":":     return M_COLON;
			"<":     return M_LT;
			">":     return M_GT;
			"!":     return M_BANG;
			"&":     return M_AMP;
			"|":     return M_PIPE;
			default: return M_IDLE;
		endcase
	endfunction

	function automatic logic [5:0] fresh_kind(input logic [7:0] v);
		unique case (v)
			"=":     return stt_pkg::KIND_EQ;
			";":     return stt_pkg::KIND_SEMI;
			"+":     return stt_pkg::KIND_PLUS;
			"-":     return stt_pkg::KIND_MINUS;
			"*":     return stt_pkg::KIND_STAR;
			"(":     return stt_pkg::KIND_LPAREN;
			")":     return stt_pkg::KIND_RPAREN;
			"{":     return stt_pkg::KIND_LBRACE;
			"}":     return stt_pkg::KIND_RBRACE;
			",":     return stt_pkg::KIND_COMMA;
			default: return stt_pkg::KIND_ERR;
		endcase
	endfunction

	always_comb begin
		c    = char_data.ch;
		md   = mode_q;
		ts   = tstart_q;
		tl   = tline_q;
		len  = tlen_q;
		pf   = pref_q;
		st   = star_q;
		used = 1'b0;
		a_v  = 1'b0;
		a_t  = '0;
		b_v  = 1'b0;
		b_t  = '0;
		f_v  = 1'b0;
		f_t  = '0;
		fm   = fresh_mode(c);

		// Continue or close the pending token.
		unique case (mode_q)
			M_STR: begin
				len  = grow(len);
				used = 1'b1;
				if (c == "\"") begin
					a_v = 1'b1;
					a_t = flush_tok(M_STR, ts, len, tl, pf);
					md  = M_IDLE;
				end
			end
			M_CMT: begin
				len  = grow(len);
				used = 1'b1;
				if (star_q && c == "/") begin
					st  = 1'b0;
					a_v = 1'b1;
					a_t = flush_tok(M_CMT, ts, len, tl, pf);
					md  = M_IDLE;
				end else begin
					st = (c == "*");
				end
			end
			M_NUM, M_IDENT, M_SLASH: begin
				if (mode_q == M_NUM && (is_digit(c) || c == ".")) begin
					len  = grow(len);
					used = 1'b1;
				end else if (mode_q == M_IDENT && (is_alpha(c) || is_digit(c) || c == "_")) begin
					if (len < 16'(KEYWORD_MAX_CHARS))
						pf = {pf[PFW-9:0], c};
					len  = grow(len);
					used = 1'b1;
				end else if (mode_q == M_SLASH && c == "*") begin
					md   = M_CMT;
					len  = 16'd2;
					st   = 1'b1;
					used = 1'b1;
				end else begin
					a_v = 1'b1;
					a_t = flush_tok(mode_q, ts, len, tl, pf);
					md  = M_IDLE;
				end
			end
			M_COLON, M_LT, M_GT, M_BANG, M_AMP, M_PIPE: begin
				a_v = 1'b1;
				md  = M_IDLE;
				if (c == pair_second(mode_q)) begin
					used = 1'b1;
					a_t              = '0;
					a_t.kind         = pair_kind(mode_q);
					a_t.start_offset = start32(ts);
					a_t.token_length = 16'd2;
					a_t.line         = sat_line(tl);
				end else begin
					a_t = flush_tok(mode_q, ts, len, tl, pf);
				end
			end
			default: md = M_IDLE;
		endcase

		// Scan the byte fresh when the pending token did not take it.
		if (!used && !is_space(c)) begin
			if (fm != M_IDLE) begin
				md  = fm;
				ts  = pos_q;
				tl  = line_q;
				len = 16'd1;
				if (fm == M_IDENT)
					pf = PFW'(c);
			end else begin
				b_v              = 1'b1;
				b_t.kind         = fresh_kind(c);
				b_t.start_offset = start32(pos_q);
				b_t.token_length = 16'd1;
				b_t.line         = sat_line(line_q);
				b_t.bad_char     = (fresh_kind(c) == stt_pkg::KIND_ERR) ? c : 8'd0;
			end
		end

		line_nx = (c == "\n" && line_q != '1) ? line_q + LW'(1) : line_q;
		pos_nx  = pos_q + PW'(1);

		// End of text: flush whatever is open and return to reset state.
		if (char_data.final_byte) begin
			f_v     = (md != M_IDLE);
			f_t     = flush_tok(md, ts, len, tl, pf);
			md      = M_IDLE;
			pos_nx  = '0;
			line_nx = LW'(1);
			ts      = '0;
			tl      = LW'(1);
			len     = 16'd0;
			pf      = '0;
			st      = 1'b0;
		end

		// Pack the valid tokens in order and mark the last one.
		results.cnt    = 2'(a_v) + 2'(b_v) + 2'(f_v);
		results.first  = a_v ? a_t : (b_v ? b_t : f_t);
		results.second = (a_v && b_v) ? b_t : f_t;
		results.first.last_of_run  = (results.cnt == 2'd1);
		results.second.last_of_run = (results.cnt == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			pos_q    <= '0;
			line_q   <= LW'(1);
			tstart_q <= '0;
			tline_q  <= LW'(1);
			tlen_q   <= 16'd0;
			pref_q   <= '0;
			star_q   <= 1'b0;
		end else if (go) begin
			mode_q   <= md;
			pos_q    <= pos_nx;
			line_q   <= line_nx;
			tstart_q <= ts;
			tline_q  <= tl;
			tlen_q   <= len;
			pref_q   <= pf;
			star_q   <= st;
		end
	end

	a_final_resets: assert property (@(posedge clk) disable iff (!arst_n)
		go && char_data.final_byte |=> mode_q == M_IDLE && pos_q == '0 && line_q == LW'(1))
		else $error("scanner state not cleared after end of text");

	a_at_most_two: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> results.cnt != 2'd3)
		else $error("more than two tokens from one byte");

	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		go && results.cnt == 2'd2 |-> !results.first.last_of_run && results.second.last_of_run)
		else $error("last_of_run on wrong token of a pair");

endmodule

`default_nettype wire

[hw/rtl/stt_result_queue.sv]
// Small token queue between the scanner and the output channel.
`timescale 1ns / 1ps
`default_nettype none

module stt_result_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire stt_pkg::res_pair_t results,
	output logic                    room,
	output logic                    tok_valid,
	input  wire logic               tok_stall,
	output stt_pkg::tok_t           tok_data
);

	stt_pkg::tok_t                 entry_q [stt_pkg::QDEPTH];
	logic [stt_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q, wr_next;
	logic [stt_pkg::QCNT_W-1:0]    count_q;
	logic [1:0]                    push_n;
	logic                          pop;

	assign push_n    = push ? results.cnt : 2'd0;
	assign pop       = tok_valid && !tok_stall;
	assign wr_next   = wr_ptr_q + stt_pkg::QPTR_W'(1);
	assign tok_valid = (count_q != '0);
	assign tok_data  = entry_q[rd_ptr_q];
	// Keep space for a full pair of tokens.
	assign room      = (count_q <= stt_pkg::QCNT_W'(stt_pkg::QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			entry_q[wr_ptr_q] <= results.first;
		if (push_n == 2'd2)
			entry_q[wr_next] <= results.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + stt_pkg::QPTR_W'(push_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + stt_pkg::QPTR_W'(1);
			count_q <= count_q + stt_pkg::QCNT_W'(push_n) - stt_pkg::QCNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= stt_pkg::QCNT_W'(stt_pkg::QDEPTH))
		else $error("token queue overflow");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push_n == 2'd0 |=> count_q == $past(count_q) - stt_pkg::QCNT_W'(1))
		else $error("token queue count did not drop on pop");

endmodule

`default_nettype wire

[hw/rtl/source_text_tokenizer.sv]
// Source text tokenizer: bytes in, one transaction per finished token out.
//
// Input channel char_*: one byte of text per transaction, final_byte set on
// the last byte of a text. Output channel tok_*: kind, start offset, length,
// start line and offending byte of each token; last_of_run marks the last
// token caused by one input byte (a byte causes zero, one or two tokens).
// A transaction completes on a rising edge with valid high and stall low.
//
// A byte is held in an input register, scanned in one pass and its tokens
// are written into a four-entry queue. The first token of a byte is offered
// on tok_* once the input register and then the queue have taken it. One
// byte is taken per cycle while char_stall is low; the rate is set by the
// output port, one token per cycle while tok_stall is low, so a byte that
// closes two tokens at once needs two output transactions.
// char_stall rises while a byte waits and the queue cannot hold two more
// tokens, so a stalled receiver holds back input once the queue fills; nothing is lost.
// Reset clears the scanner to line one, offset zero, and empties the queue.
// After a final byte the scanner returns to that same state by itself.
`timescale 1ns / 1ps
`default_nettype none

module source_text_tokenizer #(
	parameter int POSITION_BITS     = 32,
	parameter int LINE_BITS         = 16,
	parameter int KEYWORD_MAX_CHARS = 6
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            char_valid,
	output logic                 char_stall,
	input  wire stt_pkg::char_t  char_data,
	output logic                 tok_valid,
	input  wire logic            tok_stall,
	output stt_pkg::tok_t        tok_data
);

	logic                valid_s1;
	stt_pkg::char_t      char_s1;
	logic                room, go, take;
	stt_pkg::res_pair_t  results;

	assign go         = valid_s1 && room;
	assign char_stall = valid_s1 && !room;
	assign take       = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			char_s1 <= char_data;
	end

	stt_scan_core #(
		.POSITION_BITS     (POSITION_BITS),
		.LINE_BITS         (LINE_BITS),
		.KEYWORD_MAX_CHARS (KEYWORD_MAX_CHARS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.char_data (char_s1),
		.results   (results)
	);

	stt_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (go),
		.results   (results),
		.room      (room),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_data  (tok_data)
	);

endmodule

`default_nettype wire

[sim/source_text_tokenizer_checker.sv]
// Checker for the source text tokenizer: predicts the tokens of each accepted byte and compares them.
`timescale 1ns / 1ps

module source_text_tokenizer_checker
	import stt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  char_valid,
	input  logic  char_stall,
	input  char_t char_data,
	input  logic  tok_valid,
	input  logic  tok_stall,
	input  tok_t  tok_data,
	output int    fail_count,
	output int    tokens_due
);

	localparam int         KEYWORD_CHARS = 6;
	localparam logic [7:0] CH_NEWLINE    = 8'h0A;

	typedef enum logic [3:0] {
		SCAN_IDLE, SCAN_STRING, SCAN_NUMBER, SCAN_COMMENT, SCAN_WORD, SCAN_SLASH,
		SCAN_COLON, SCAN_LT, SCAN_GT, SCAN_BANG, SCAN_AMP, SCAN_PIPE
	} scan_mode_t;

	scan_mode_t  mode;
	logic [31:0] byte_pos;
	logic [15:0] cur_line;
	logic [31:0] tok_start;
	logic [15:0] tok_line;
	logic [15:0] tok_len;
	logic [47:0] word_text;
	logic        star_pending;

	tok_t expected_tokens[$];
	tok_t held_tok;
	bit   held_valid;

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic void clear_scanner();
		mode = SCAN_IDLE;
		byte_pos = '0;
		cur_line = 16'd1;
		tok_start = '0;
		tok_line = 16'd1;
		tok_len = '0;
		word_text = '0;
		star_pending = 1'b0;
	endfunction

	// Hold the newest token back so the last one of a byte can be marked.
	function automatic void emit(logic [5:0] kind, logic [31:0] start, logic [15:0] len,
			logic [15:0] ln, logic [7:0] bad);
		if (held_valid)
			expected_tokens = {expected_tokens, held_tok};
		held_tok.kind = kind;
		held_tok.start_offset = start;
		held_tok.token_length = len;
		held_tok.line = ln;
		held_tok.bad_char = bad;
		held_tok.last_of_run = 1'b0;
		held_valid = 1'b1;
	endfunction

	function automatic void start_token(scan_mode_t m, logic [31:0] pos, logic [15:0] ln);
		mode = m;
		tok_start = pos;
		tok_line = ln;
		tok_len = 16'd1;
	endfunction

	function automatic void lengthen();
		if (tok_len != 16'hFFFF)
			tok_len++;
	endfunction

	function automatic logic [5:0] word_kind();
		if (tok_len > KEYWORD_CHARS)
			return KIND_IDENT;
		case (word_text)
			48'("int"):    return KIND_KW0;
			48'("float"):  return KIND_KW0 + 6'd1;
			48'("string"): return KIND_KW0 + 6'd2;
			48'("read"):   return KIND_KW0 + 6'd3;
			48'("write"):  return KIND_KW0 + 6'd4;
			48'("repeat"): return KIND_KW0 + 6'd5;
			48'("until"):  return KIND_KW0 + 6'd6;
			48'("if"):     return KIND_KW0 + 6'd7;
			48'("elseif"): return KIND_KW0 + 6'd8;
			48'("else"):   return KIND_KW0 + 6'd9;
			48'("then"):   return KIND_KW0 + 6'd10;
			48'("return"): return KIND_KW0 + 6'd11;
			48'("end"):    return KIND_KW0 + 6'd12;
			default:       return KIND_IDENT;
		endcase
	endfunction

	// Emit the pending token as it stands and drop back to idle.
	function automatic void flush_token();
		case (mode)
			SCAN_STRING:  emit(KIND_STRING, tok_start, tok_len, tok_line, 8'd0);
			SCAN_NUMBER:  emit(KIND_NUMBER, tok_start, tok_len, tok_line, 8'd0);
			SCAN_COMMENT: emit(KIND_COMMENT, tok_start, tok_len, tok_line, 8'd0);
			SCAN_WORD:    emit(word_kind(), tok_start, tok_len, tok_line, 8'd0);
			SCAN_SLASH:   emit(KIND_SLASH, tok_start, 16'd1, tok_line, 8'd0);
			SCAN_COLON:   emit(KIND_COLON, tok_start, 16'd1, tok_line, 8'd0);
			SCAN_LT:      emit(KIND_LT, tok_start, 16'd1, tok_line, 8'd0);
			SCAN_GT:      emit(KIND_GT, tok_start, 16'd1, tok_line, 8'd0);
			SCAN_BANG:    emit(KIND_ERR, tok_start, 16'd1, tok_line, "!");
			SCAN_AMP:     emit(KIND_ERR, tok_start, 16'd1, tok_line, "&");
			SCAN_PIPE:    emit(KIND_ERR, tok_start, 16'd1, tok_line, "|");
			default: ;
		endcase
		mode = SCAN_IDLE;
	endfunction

	function automatic void scan_first(logic [7:0] c, logic [31:0] pos, logic [15:0] ln);
		if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
			return;
		end else if (c == "\"") begin
			start_token(SCAN_STRING, pos, ln);
		end else if (is_digit(c)) begin
			start_token(SCAN_NUMBER, pos, ln);
		end else if (c == "/") begin
			start_token(SCAN_SLASH, pos, ln);
		end else if (is_alpha(c) || c == "_") begin
			start_token(SCAN_WORD, pos, ln);
			word_text = {40'd0, c};
		end else begin
			case (c)
				":": start_token(SCAN_COLON, pos, ln);
				"<": start_token(SCAN_LT, pos, ln);
				">": start_token(SCAN_GT, pos, ln);
				"!": start_token(SCAN_BANG, pos, ln);
				"&": start_token(SCAN_AMP, pos, ln);
				"|": start_token(SCAN_PIPE, pos, ln);
				"=": emit(KIND_EQ, pos, 16'd1, ln, 8'd0);
				";": emit(KIND_SEMI, pos, 16'd1, ln, 8'd0);
				"+": emit(KIND_PLUS, pos, 16'd1, ln, 8'd0);
				"-": emit(KIND_MINUS, pos, 16'd1, ln, 8'd0);
				"*": emit(KIND_STAR, pos, 16'd1, ln, 8'd0);
				"(": emit(KIND_LPAREN, pos, 16'd1, ln, 8'd0);
				")": emit(KIND_RPAREN, pos, 16'd1, ln, 8'd0);
				"{": emit(KIND_LBRACE, pos, 16'd1, ln, 8'd0);
				"}": emit(KIND_RBRACE, pos, 16'd1, ln, 8'd0);
				",": emit(KIND_COMMA, pos, 16'd1, ln, 8'd0);
				default: emit(KIND_ERR, pos, 16'd1, ln, c);
			endcase
		end
	endfunction

	// Complete a pending two-byte operator, or emit it alone and rescan the byte.
	function automatic bit pair_op(logic [7:0] c, logic [7:0] second, logic [5:0] kind);
		if (c == second) begin
			emit(kind, tok_start, 16'd2, tok_line, 8'd0);
			mode = SCAN_IDLE;
			return 1'b1;
		end
		flush_token();
		return 1'b0;
	endfunction

	function automatic void scan_byte(logic [7:0] c, logic fin);
		logic [31:0] pos;
		logic [15:0] ln;
		bit          used;
		pos = byte_pos;
		ln = cur_line;
		used = 1'b0;
		case (mode)
			SCAN_STRING: begin
				lengthen();
				used = 1'b1;
				if (c == "\"")
					flush_token();
			end
			SCAN_COMMENT: begin
				lengthen();
				used = 1'b1;
				if (star_pending && c == "/") begin
					star_pending = 1'b0;
					flush_token();
				end else begin
					star_pending = (c == "*");
				end
			end
			SCAN_NUMBER: begin
				if (is_digit(c) || c == ".") begin
					lengthen();
					used = 1'b1;
				end else begin
					flush_token();
				end
			end
			SCAN_WORD: begin
				if (is_alpha(c) || is_digit(c) || c == "_") begin
					if (tok_len < KEYWORD_CHARS)
						word_text = {word_text[39:0], c};
					lengthen();
					used = 1'b1;
				end else begin
					flush_token();
				end
			end
			SCAN_SLASH: begin
				// The opening star also counts toward the closing pair.
				if (c == "*") begin
					mode = SCAN_COMMENT;
					tok_len = 16'd2;
					star_pending = 1'b1;
					used = 1'b1;
				end else begin
					flush_token();
				end
			end
			SCAN_COLON: used = pair_op(c, "=", KIND_ASSIGN);
			SCAN_LT:    used = pair_op(c, "=", KIND_LE);
			SCAN_GT:    used = pair_op(c, "=", KIND_GE);
			SCAN_BANG:  used = pair_op(c, "=", KIND_NE);
			SCAN_AMP:   used = pair_op(c, "&", KIND_LOGIC);
			SCAN_PIPE:  used = pair_op(c, "|", KIND_LOGIC);
			default:    mode = SCAN_IDLE;
		endcase
		if (!used)
			scan_first(c, pos, ln);
		if (c == CH_NEWLINE && cur_line != 16'hFFFF)
			cur_line++;
		byte_pos = pos + 32'd1;
		if (fin) begin
			flush_token();
			clear_scanner();
		end
		if (held_valid) begin
			held_tok.last_of_run = 1'b1;
			expected_tokens = {expected_tokens, held_tok};
			held_valid = 1'b0;
		end
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic void check_token(tok_t got);
		tok_t want;
		if (expected_tokens.size() == 0) begin
			$error("token transaction with nothing expected: kind %0d, offset %0d",
				got.kind, got.start_offset);
			fail_count++;
		end else begin
			want = expected_tokens.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("start_offset", want.start_offset, got.start_offset);
			compare_field("token_length", want.token_length, got.token_length);
			compare_field("line", want.line, got.line);
			compare_field("bad_char", want.bad_char, got.bad_char);
			compare_field("last_of_run", want.last_of_run, got.last_of_run);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scanner();
			expected_tokens.delete();
			held_valid = 1'b0;
			fail_count = 0;
		end else begin
			// Predict first so a token is never compared ahead of its byte.
			if (char_valid && !char_stall)
				scan_byte(char_data.ch, char_data.final_byte);
			if (tok_valid && !tok_stall)
				check_token(tok_data);
		end
		tokens_due = expected_tokens.size();
	end

endmodule

[sim/source_text_tokenizer_test.sv]
// Testbench top for the source text tokenizer: drives text and stalls, gives the verdict.
`timescale 1ns / 1ps

module source_text_tokenizer_test;
	import stt_pkg::*;

	localparam int         RANDOM_BYTES = 1230;
	localparam int         DRAIN_LIMIT  = 20000;
	localparam int         SETTLE       = 20;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;

	logic  clk;
	logic  arst_n;
	logic  char_valid;
	logic  char_stall;
	char_t char_data;
	logic  tok_valid;
	logic  tok_stall;
	tok_t  tok_data;
	int    fail_count;
	int    tokens_due;

	logic [7:0] text[$];
	bit         steady;

	source_text_tokenizer i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.tok_valid  (tok_valid),
		.tok_stall  (tok_stall),
		.tok_data   (tok_data)
	);

	source_text_tokenizer_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.tok_valid  (tok_valid),
		.tok_stall  (tok_stall),
		.tok_data   (tok_data),
		.fail_count (fail_count),
		.tokens_due (tokens_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Mostly no gap, some short ones, a few long ones.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic string keyword_text(int k);
		case (k)
			0:  return "int";
			1:  return "float";
			2:  return "string";
			3:  return "read";
			4:  return "write";
			5:  return "repeat";
			6:  return "until";
			7:  return "if";
			8:  return "elseif";
			9:  return "else";
			10: return "then";
			11: return "return";
			default: return "end";
		endcase
	endfunction

	function automatic string op_text(int k);
		case (k)
			0:  return ":=";
			1:  return ":";
			2:  return "<=";
			3:  return "<";
			4:  return ">=";
			5:  return ">";
			6:  return "=";
			7:  return "!=";
			8:  return "&&";
			9:  return "||";
			10: return ";";
			11: return "+";
			12: return "-";
			13: return "*";
			14: return "/";
			15: return "(";
			16: return ")";
			17: return "{";
			18: return "}";
			default: return ",";
		endcase
	endfunction

	function automatic logic [7:0] word_char(bit first);
		int r;
		r = first ? $urandom_range(0, 52) : $urandom_range(0, 62);
		if (r < 26)
			return 8'("a" + r);
		if (r < 52)
			return 8'("A" + r - 26);
		if (r == 52)
			return "_";
		return 8'("0" + r - 53);
	endfunction

	function automatic void add_byte(logic [7:0] c);
		text = {text, c};
	endfunction

	function automatic void add_string(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endfunction

	function automatic logic [7:0] body_char();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return CH_NEWLINE;
		if (r == 1)
			return "*";
		return 8'($urandom_range(32, 126));
	endfunction

	// Append one token of random kind and content, then maybe a separator.
	function automatic void add_token();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		n = $urandom_range(0, 8);
		if (pick < 15) begin
			add_string(keyword_text($urandom_range(0, 12)));
		end else if (pick < 30) begin
			if ($urandom_range(0, 3) == 0)
				add_string(keyword_text($urandom_range(0, 12)));
			else
				add_byte(word_char(1'b1));
			repeat (n) add_byte(word_char(1'b0));
		end else if (pick < 40) begin
			add_byte(8'("0" + $urandom_range(0, 9)));
			repeat (n) add_byte($urandom_range(0, 4) == 0 ? 8'(".") :
				8'("0" + $urandom_range(0, 9)));
		end else if (pick < 48) begin
			add_byte("\"");
			repeat (n) add_byte(body_char());
			if ($urandom_range(0, 9) != 0)
				add_byte("\"");
		end else if (pick < 56) begin
			add_string("/*");
			repeat (n) add_byte(body_char());
			if ($urandom_range(0, 9) != 0)
				add_string("*/");
		end else if (pick < 82) begin
			add_string(op_text($urandom_range(0, 19)));
		end else if (pick < 92) begin
			add_byte(8'($urandom_range(0, 255)));
		end else begin
			case ($urandom_range(0, 2))
				0: add_byte("!");
				1: add_byte("&");
				default: add_byte("|");
			endcase
		end
		case ($urandom_range(0, 9))
			0, 1, 2: add_byte(" ");
			3: add_byte(CH_NEWLINE);
			4: add_byte(8'h09);
			5: add_byte(8'h0D);
			default: ;
		endcase
	endfunction

	// Call at a falling edge; returns at the falling edge after the transaction.
	task automatic push_byte(logic [7:0] c, logic fin);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_data <= '{ch: c, final_byte: fin};
		char_valid <= 1'b1;
		do @(posedge clk); while (char_stall);
		@(negedge clk);
	endtask

	task automatic send_text();
		steady = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < text.size(); i++)
			push_byte(text[i], i == text.size() - 1);
		text.delete();
	endtask

	initial begin
		int run;
		int hold;
		tok_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 12);
			repeat (run) @(negedge clk);
			hold = idle_len();
			if (hold > 0) begin
				tok_stall <= 1'b1;
				repeat (hold) @(negedge clk);
				tok_stall <= 1'b0;
			end
		end
	end

	initial begin
		int sent;
		int waited;
		arst_n <= 1'b0;
		char_valid <= 1'b0;
		char_data <= '0;
		steady = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Comment closed by its own opening star.
		add_string("/*/");
		send_text();
		// Newline inside a string that runs to the end of the text.
		add_string("\"a");
		add_byte(CH_NEWLINE);
		add_string("b");
		send_text();
		// Lone operators, control and high bytes, colon flushed at the end.
		add_string("!&|");
		add_byte(8'h00);
		add_byte(8'hFF);
		add_string(":");
		send_text();
		// Longest keyword closed by a pending less-than.
		add_string("elseif<");
		send_text();

		sent = 0;
		while (sent < RANDOM_BYTES) begin
			repeat ($urandom_range(1, 12)) add_token();
			sent += text.size();
			send_text();
		end
		char_valid <= 1'b0;

		waited = 0;
		while (tokens_due != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (tokens_due != 0) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			repeat (SETTLE) @(negedge clk);
			if (fail_count == 0)
				$display("end of test: clean");
			else
				$display("end of test: mismatches");
			$finish;
		end
	end

endmodule
